FILE: rtl/mfde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame-store draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

    localparam int FRAME_WIDTH_DEF  = 128;
    localparam int FRAME_HEIGHT_DEF = 64;
    localparam int SPRITE_EDGE_DEF  = 8;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_SET   = 3'd1,
        OP_GET   = 3'd2,
        OP_FILL  = 3'd3,
        OP_BLIT  = 3'd4
    } t_op;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic        kind_clear;
        logic        kind_get;
        logic        kind_walk;   // set, fill or blit: walk a pixel window
        logic        use_mask;    // blit: write ink only at set bits
        logic        reject;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [8:0]  x_end;       // exclusive, clipped
        logic [8:0]  y_end;       // exclusive, clipped
        logic        ink;
        logic [63:0] bits;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_WAIT,
        ST_CHECK,
        ST_RESULT,
        ST_INIT
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/mfde_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mfde_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one word per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/mfde_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_front
// Accept command items, classify and clip them, and queue them for the back.
// ----------------------------------------------------------------------------
module mfde_front #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64,
    parameter int SPRITE_EDGE  = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_operation,
    input  wire logic [7:0]    i_pos_x,
    input  wire logic [7:0]    i_pos_y,
    input  wire logic [8:0]    i_rect_width,
    input  wire logic [8:0]    i_rect_height,
    input  wire logic          i_ink,
    input  wire logic [63:0]   i_sprite_bits,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_take,
    output mfde_pkg::t_cmd     o_cmd
);
    import mfde_pkg::*;

    localparam logic [9:0] FW = 10'(FRAME_WIDTH);
    localparam logic [9:0] FH = 10'(FRAME_HEIGHT);
    localparam logic [9:0] SE = 10'(SPRITE_EDGE);

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       on_scr;
    logic [9:0] xe, ye;
    logic       push, pop;

    assign o_stall     = (r_cnt == 2'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Classify the item and clip its window.
    always_comb begin
        on_scr = ({2'b0, i_pos_x} < FW) && ({2'b0, i_pos_y} < FH);
        xe = 10'(i_pos_x) + 10'(i_rect_width);
        ye = 10'(i_pos_y) + 10'(i_rect_height);
        n_cmd = '0;
        n_cmd.x0   = i_pos_x;
        n_cmd.y0   = i_pos_y;
        n_cmd.ink  = i_ink;
        n_cmd.bits = i_sprite_bits;
        unique case (i_operation)
            OP_CLEAR: n_cmd.kind_clear = 1'b1;
            OP_SET: begin
                n_cmd.reject    = !on_scr;
                n_cmd.kind_walk = on_scr;
                n_cmd.x_end     = 9'(i_pos_x) + 9'd1;
                n_cmd.y_end     = 9'(i_pos_y) + 9'd1;
            end
            OP_GET: begin
                n_cmd.reject   = !on_scr;
                n_cmd.kind_get = on_scr;
            end
            OP_FILL: begin
                n_cmd.reject    = !on_scr || i_rect_width == 9'd0 || i_rect_height == 9'd0;
                n_cmd.kind_walk = !n_cmd.reject;
                if (xe > FW) xe = FW;
                if (ye > FH) ye = FH;
                n_cmd.x_end = 9'(xe);
                n_cmd.y_end = 9'(ye);
            end
            OP_BLIT: begin
                n_cmd.use_mask = 1'b1;
                n_cmd.ink      = 1'b1;
                xe = 10'(i_pos_x) + SE;
                ye = 10'(i_pos_y) + SE;
                if (xe > FW) xe = FW;
                if (ye > FH) ye = FH;
                n_cmd.kind_walk = on_scr;
                n_cmd.x_end = 9'(xe);
                n_cmd.y_end = 9'(ye);
            end
            default: n_cmd.reject = 1'b1;
        endcase
    end

    // Hold pointers and fill count of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Store the queued item.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
    end
endmodule
`default_nettype wire

FILE: rtl/mfde_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_back
// Walk the frame store one pixel at a time and deliver one result per item.
// ----------------------------------------------------------------------------
module mfde_back #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_take,
    input  wire mfde_pkg::t_cmd i_cmd,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic             o_pixel_value,
    output logic [31:0]      o_change_count
);
    import mfde_pkg::*;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [7:0]  r_x, r_y, n_x, n_y;
    logic [AW:0] r_clr, n_clr;
    logic [31:0] r_count, n_count;
    logic        r_stat, r_pix, n_stat, n_pix;
    logic        we, wdata;
    logic [AW-1:0] addr;
    logic        rdata;
    logic        last_x, last_y, bit_on;
    logic [AW-1:0] pix_addr;

    assign pix_addr = AW'(r_y) * AW'(FRAME_WIDTH) + AW'(r_x);
    assign last_x   = (9'(r_x) + 9'd1) >= r_cmd.x_end;
    assign last_y   = (9'(r_y) + 9'd1) >= r_cmd.y_end;
    assign bit_on   = r_cmd.bits[{3'(r_y - r_cmd.y0), 3'(r_x - r_cmd.x0)}];

    mfde_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    assign o_valid        = (r_state == ST_RESULT);
    assign o_status       = r_stat;
    assign o_pixel_value  = r_pix;
    assign o_change_count = r_count;

    // Sequence clear, read-compare-write walk and result.
    always_comb begin
        n_state = r_state;
        n_x = r_x; n_y = r_y; n_clr = r_clr; n_count = r_count;
        n_stat = r_stat; n_pix = r_pix;
        we = 1'b0; wdata = 1'b0; addr = pix_addr;
        o_cmd_take = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_take = i_cmd_valid;
                if (i_cmd_valid) begin
                    n_x = i_cmd.x0; n_y = i_cmd.y0;
                    n_stat = i_cmd.reject; n_pix = 1'b0;
                    n_clr = '0;
                    if (i_cmd.kind_clear) begin
                        n_count = '0;
                        n_state = ST_CLEAR;
                    end else if (i_cmd.kind_get || i_cmd.kind_walk) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            // Sweep after reset, then go idle without a result
            ST_INIT: begin
                we = 1'b1; addr = r_clr[AW-1:0];
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                we = 1'b1; addr = r_clr[AW-1:0];
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(DEPTH - 1)) n_state = ST_RESULT;
            end
            ST_READ: n_state = ST_WAIT;
            ST_WAIT: n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_cmd.kind_get) begin
                    n_pix = rdata;
                    n_state = ST_RESULT;
                end else begin
                    if ((!r_cmd.use_mask || bit_on) && rdata != r_cmd.ink) begin
                        we = 1'b1; wdata = r_cmd.ink;
                        n_count = r_count + 32'd1;
                    end
                    if (!last_x) begin
                        n_x = r_x + 8'd1;
                        n_state = ST_READ;
                    end else if (!last_y) begin
                        n_x = r_cmd.x0; n_y = r_y + 8'd1;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
            r_count <= '0;
            r_stat  <= 1'b0;
            r_pix   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_stat  <= n_stat;
            r_pix   <= n_pix;
        end
    end

    // Capture the item and walk position.
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) r_cmd <= i_cmd;
        r_x <= n_x;
        r_y <= n_y;
    end
endmodule
`default_nettype wire

FILE: rtl/mono_framebuffer_draw_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// One-bit frame store with clear, set, get, clipped fill and sprite blit.
//
// Input items arrive on i_valid/o_stall with one port per field; each gives
// exactly one result on o_valid/i_stall (status, pixel_value, change_count).
// A front stage classifies and clips each item into a two-entry queue, so
// items are taken while the back still works or its result waits.
// The back walks pixels through the single RAM port, each pixel in turn
// through a read, a wait for the registered read, and a compare and write.
// Clear sweeps one word a cycle over all FRAME_WIDTH*FRAME_HEIGHT words
// (8192). After reset the same sweep runs first; items are queued
// meanwhile but not executed. A stalled result holds and blocks the back.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
    parameter int FRAME_WIDTH  = mfde_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mfde_pkg::FRAME_HEIGHT_DEF,
    parameter int SPRITE_EDGE  = mfde_pkg::SPRITE_EDGE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [8:0]  i_rect_width,
    input  wire logic [8:0]  i_rect_height,
    input  wire logic        i_ink,
    input  wire logic [63:0] i_sprite_bits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic             o_pixel_value,
    output logic [31:0]      o_change_count
);
    import mfde_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_take;

    mfde_front #(
        .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT),
        .SPRITE_EDGE(SPRITE_EDGE)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_ink(i_ink), .i_sprite_bits(i_sprite_bits),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    mfde_back #(
        .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take), .i_cmd(cmd),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_pixel_value(o_pixel_value),
        .o_change_count(o_change_count)
    );
endmodule
`default_nettype wire

FILE: verif/tb_mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine
// Drives clear, set, get, fill, sprite and undefined-operation items into the
// draw engine with random idling on both sides, predicts every result from a
// private copy of the frame store and change count, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import mfde_pkg::*;

    localparam int FW = 128;
    localparam int FH = 64;
    localparam int SE = 8;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [8:0]  rw;
        logic [8:0]  rh;
        logic        ink;
        logic [63:0] bits;
    } t_draw;

    typedef struct {
        logic        status;
        logic        pix;
        logic [31:0] count;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_operation = '0;
    logic [7:0]  i_pos_x = '0;
    logic [7:0]  i_pos_y = '0;
    logic [8:0]  i_rect_width = '0;
    logic [8:0]  i_rect_height = '0;
    logic        i_ink = 1'b0;
    logic [63:0] i_sprite_bits = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic        o_status;
    logic        o_pixel_value;
    logic [31:0] o_change_count;

    mono_framebuffer_draw_engine i_dut (.*);

    always #10 i_clk = ~i_clk;

    // Model state of the frame and its change count
    bit          shadow_frame [FW*FH];
    logic [31:0] shadow_changes;

    t_draw   pending_draws[$];
    t_answer awaited_answers[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off_cycles = 0;
    int      mismatches = 0;
    int      cycles = 0;

    function automatic void paint_pixel(input int x, input int y, input bit v);
        if (x < FW && y < FH && shadow_frame[y*FW + x] != v) begin
            shadow_frame[y*FW + x] = v;
            shadow_changes++;
        end
    endfunction

    function automatic t_answer draw_outcome(input t_draw d);
        t_answer a;
        int      xe;
        int      ye;
        bit      on_screen;
        a = '{1'b0, 1'b0, 32'd0};
        on_screen = d.px < FW && d.py < FH;
        case (d.op)
            OP_CLEAR: begin
                foreach (shadow_frame[i]) shadow_frame[i] = 1'b0;
                shadow_changes = '0;
            end
            OP_SET: begin
                if (on_screen) paint_pixel(d.px, d.py, d.ink);
                else a.status = 1'b1;
            end
            OP_GET: begin
                if (on_screen) a.pix = shadow_frame[d.py*FW + d.px];
                else a.status = 1'b1;
            end
            OP_FILL: begin
                if (d.rw == 0 || d.rh == 0 || !on_screen) begin
                    a.status = 1'b1;
                end else begin
                    xe = (d.px + d.rw > FW) ? FW : d.px + d.rw;
                    ye = (d.py + d.rh > FH) ? FH : d.py + d.rh;
                    for (int r = d.py; r < ye; r++)
                        for (int c = d.px; c < xe; c++) paint_pixel(c, r, d.ink);
                end
            end
            OP_BLIT: begin
                for (int r = 0; r < SE; r++)
                    for (int c = 0; c < SE; c++)
                        if (d.bits[r*8 + c]) paint_pixel(d.px + c, d.py + r, 1'b1);
            end
            default: a.status = 1'b1;
        endcase
        a.count = shadow_changes;
        return a;
    endfunction

    // Driver: offer queued items, hold a stalled item steady
    always @(posedge i_clk) begin
        t_draw d;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) awaited_answers.push_back(draw_outcome(pending_draws.pop_front()));
            if (pending_draws.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                d = pending_draws[0];
                i_valid       <= 1'b1;
                i_operation   <= d.op;
                i_pos_x       <= d.px;
                i_pos_y       <= d.py;
                i_rect_width  <= d.rw;
                i_rect_height <= d.rh;
                i_ink         <= d.ink;
                i_sprite_bits <= d.bits;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down in its own process
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
    end

    // Monitor: check each accepted result and pick the next stall
    always @(posedge i_clk) begin
        t_answer e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = awaited_answers.pop_front();
                if (o_status !== e.status || o_pixel_value !== e.pix ||
                    o_change_count !== e.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d px=%0d cnt=%0d got st=%0d px=%0d cnt=%0d",
                                 e.status, e.pix, e.count,
                                 o_status, o_pixel_value, o_change_count);
                end
            end
        end
        i_stall <= !i_rst_n || hold_off_cycles > 1 || $urandom_range(99) < recv_stall_pct;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL mono_framebuffer_draw_engine");
            $finish;
        end
    end

    function automatic t_draw random_draw();
        t_draw d;
        int    pick;
        d.op   = 3'($urandom_range(4));
        pick   = $urandom_range(99);
        if (pick < 3) d.op = 3'($urandom_range(7, 5));
        else if (pick < 5) d.op = OP_CLEAR;
        else if (d.op == OP_CLEAR) d.op = OP_GET;
        // Mostly on-screen coordinates, sometimes anything
        d.px   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(FW - 1));
        d.py   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(FH - 1));
        d.rw   = ($urandom_range(19) == 0) ? 9'($urandom) : 9'($urandom_range(6));
        d.rh   = ($urandom_range(19) == 0) ? 9'($urandom) : 9'($urandom_range(6));
        d.ink  = 1'($urandom);
        d.bits = {$urandom, $urandom};
        // Keep large fills rare, they are slow
        if (d.op == OP_FILL && (d.rw > 16 || d.rh > 16) && $urandom_range(3) != 0) begin
            d.rw = 9'($urandom_range(16));
            d.rh = 9'($urandom_range(16));
        end
        return d;
    endfunction

    task automatic wait_drained();
        while (pending_draws.size() > 0 || i_valid || awaited_answers.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int stall_pcts [4] = '{0, 0, 53, 19};
        int idle_pcts  [4] = '{0, 53, 0, 19};
        shadow_changes = '0;
        foreach (shadow_frame[i]) shadow_frame[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation and each corner case
        pending_draws.push_back('{OP_GET, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 64'd0});
        pending_draws.push_back('{OP_SET, 8'd127, 8'd63, 9'd0, 9'd0, 1'b1, 64'd0});
        pending_draws.push_back('{OP_GET, 8'd127, 8'd63, 9'd0, 9'd0, 1'b0, 64'd0});
        pending_draws.push_back('{OP_SET, 8'd127, 8'd63, 9'd0, 9'd0, 1'b1, 64'd0});
        pending_draws.push_back('{OP_SET, 8'd128, 8'd0, 9'd0, 9'd0, 1'b1, 64'd0});
        pending_draws.push_back('{OP_SET, 8'd0, 8'd64, 9'd0, 9'd0, 1'b1, 64'd0});
        pending_draws.push_back('{OP_GET, 8'd255, 8'd255, 9'd0, 9'd0, 1'b1, 64'd0});
        pending_draws.push_back('{OP_FILL, 8'd3, 8'd3, 9'd0, 9'd4, 1'b1, 64'd0});
        pending_draws.push_back('{OP_FILL, 8'd3, 8'd3, 9'd4, 9'd0, 1'b1, 64'd0});
        pending_draws.push_back('{OP_FILL, 8'd200, 8'd3, 9'd4, 9'd4, 1'b1, 64'd0});
        pending_draws.push_back('{OP_FILL, 8'd124, 8'd61, 9'd511, 9'd511, 1'b1, 64'd0});
        pending_draws.push_back('{OP_FILL, 8'd125, 8'd62, 9'd2, 9'd2, 1'b0, 64'd0});
        pending_draws.push_back('{OP_BLIT, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_draws.push_back('{OP_BLIT, 8'd124, 8'd60, 9'd0, 9'd0, 1'b0,
                                  64'hA55A_F00F_1234_8001});
        pending_draws.push_back('{OP_BLIT, 8'd255, 8'd255, 9'd0, 9'd0, 1'b0,
                                  64'hFFFF_FFFF_FFFF_FFFF});
        pending_draws.push_back('{OP_BLIT, 8'd10, 8'd10, 9'd0, 9'd0, 1'b0, 64'd0});
        pending_draws.push_back('{3'd5, 8'd1, 8'd1, 9'd1, 9'd1, 1'b1, 64'd1});
        pending_draws.push_back('{3'd7, 8'd1, 8'd1, 9'd1, 9'd1, 1'b1, 64'd1});
        pending_draws.push_back('{OP_GET, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 64'd0});
        pending_draws.push_back('{OP_CLEAR, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 64'd0});
        pending_draws.push_back('{OP_GET, 8'd127, 8'd63, 9'd0, 9'd0, 1'b0, 64'd0});
        wait_drained();

        // Random phases with varied idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pcts[ph];
            recv_stall_pct = stall_pcts[ph];
            repeat (145) pending_draws.push_back(random_draw());
            if (ph == 1) hold_off_cycles = 3000;
            wait_drained();
        end

        // Sender pauses until all results are in, then a last burst
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (20) pending_draws.push_back(random_draw());
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS mono_framebuffer_draw_engine");
        end else begin
            $display("FAIL mono_framebuffer_draw_engine");
        end
        $finish;
    end
endmodule
